[sv/spwc_pkg.sv]
// Shared types, constants and state encoding for the scan point window clustering block.
package spwc_pkg;

    localparam int WINDOW  = 5;
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int COORD_W = 16;
    localparam int LABEL_W = 10;
    localparam int INDEX_W = 10;
    localparam int BACK_W  = 3;
    localparam int THR_W   = 16;
    localparam int SQ_W    = 2 * COORD_W;

    localparam logic [THR_W-1:0]   THR_RESET = 16'd200;
    localparam logic [LABEL_W-1:0] LABEL_CAP = 10'd1023;
    localparam logic [INDEX_W-1:0] INDEX_MAX = 10'd1023;
    localparam logic [INDEX_W-1:0] WINDOW_FILL = INDEX_W'(WINDOW);
    localparam logic [IDX_W-1:0]   LAST_IDX = IDX_W'(WINDOW - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic [SQ_W-1:0]  dx2;
        logic [SQ_W-1:0]  dy2;
    } sq_t;

endpackage

[sv/spwc_dist.sv]
// Shared distance unit: squares the coordinate differences to one window entry per cycle.
module spwc_dist (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                issue,
    input  logic [spwc_pkg::IDX_W-1:0]          issue_idx,
    input  logic signed [spwc_pkg::COORD_W-1:0] px,
    input  logic signed [spwc_pkg::COORD_W-1:0] py,
    input  logic signed [spwc_pkg::COORD_W-1:0] wx,
    input  logic signed [spwc_pkg::COORD_W-1:0] wy,
    output spwc_pkg::sq_t                       sq
);

    logic signed [spwc_pkg::COORD_W:0]     dx;
    logic signed [spwc_pkg::COORD_W:0]     dy;
    logic signed [2*spwc_pkg::COORD_W+1:0] px2;
    logic signed [2*spwc_pkg::COORD_W+1:0] py2;
    spwc_pkg::sq_t                         sq_reg;
    spwc_pkg::sq_t                         sq_next;

    always_comb begin
        dx = {px[spwc_pkg::COORD_W-1], px} - {wx[spwc_pkg::COORD_W-1], wx};
        dy = {py[spwc_pkg::COORD_W-1], py} - {wy[spwc_pkg::COORD_W-1], wy};
        px2 = dx * dx;
        py2 = dy * dy;
        sq_next.vld = issue;
        sq_next.idx = issue_idx;
        sq_next.dx2 = px2[spwc_pkg::SQ_W-1:0];
        sq_next.dy2 = py2[spwc_pkg::SQ_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_reg.vld <= 1'b0;
        end else begin
            sq_reg.vld <= sq_next.vld;
        end
        sq_reg.idx <= sq_next.idx;
        sq_reg.dx2 <= sq_next.dx2;
        sq_reg.dy2 <= sq_next.dy2;
    end

    assign sq = sq_reg;

endmodule

[sv/scan_point_window_clustering.sv]
// Top level of the scan point window clustering block.
// A point that meets a full window passes from its transfer through the run state, in which
// the shared distance unit visits the five window entries one per cycle, then through the
// drain and finish states; an early point of a scan goes from its transfer straight to
// finish. No new point is taken until the finish state has written the result to the output
// register, which waits while the output is stalled. Reset clears the point count, the label
// counter and the handshake state and loads the distance threshold with 200.
module scan_point_window_clustering (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // point_x, point_y
    input  logic        s_tuser,   // first_of_scan
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // point_index, point_label, neighbor_back, zero fill
    output logic        m_tuser    // neighbor_got_new_label
);

    localparam int CW = spwc_pkg::COORD_W;
    localparam int LW = spwc_pkg::LABEL_W;
    localparam int IW = spwc_pkg::IDX_W;

    spwc_pkg::state_t state_reg, state_next;

    logic [spwc_pkg::THR_W-1:0]   thr_reg;
    logic [spwc_pkg::SQ_W-1:0]    thr_sq_reg;
    logic signed [CW-1:0]         px_reg, py_reg;
    logic signed [CW-1:0]         win_x_reg [spwc_pkg::WINDOW];
    logic signed [CW-1:0]         win_y_reg [spwc_pkg::WINDOW];
    logic [LW-1:0]                win_label_reg [spwc_pkg::WINDOW];
    logic [spwc_pkg::INDEX_W-1:0] seen_reg;
    logic [LW-1:0]                lab_cnt_reg;
    logic [IW-1:0]                cnt_reg;
    logic [spwc_pkg::SQ_W:0]      best_reg;
    logic [IW-1:0]                best_i_reg;
    logic                         m_tvalid_reg;
    logic [23:0]                  m_tdata_reg;
    logic                         m_tuser_reg;

    logic                         s_xfer;
    logic                         issue;
    logic                         finish_go;
    logic                         window_full;
    logic                         run_done;
    spwc_pkg::sq_t                sq;
    logic [spwc_pkg::SQ_W:0]      d2;
    logic                         joined;
    logic                         fresh;
    logic [LW-1:0]                nb_label;
    logic [LW-1:0]                lab_cnt_next;
    logic [LW-1:0]                label;
    logic [spwc_pkg::BACK_W-1:0]  back;

    spwc_dist u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .issue_idx (cnt_reg),
        .px        (px_reg),
        .py        (py_reg),
        .wx        (win_x_reg[cnt_reg]),
        .wy        (win_y_reg[cnt_reg]),
        .sq        (sq)
    );

    assign window_full = (s_tuser ? '0 : seen_reg) >= spwc_pkg::WINDOW_FILL;
    assign run_done    = cnt_reg == spwc_pkg::LAST_IDX;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spwc_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    state_next = window_full ? spwc_pkg::ST_RUN : spwc_pkg::ST_FINISH;
                end
            end
            spwc_pkg::ST_RUN: begin
                if (run_done) begin
                    state_next = spwc_pkg::ST_DRAIN;
                end
            end
            spwc_pkg::ST_DRAIN: begin
                state_next = spwc_pkg::ST_FINISH;
            end
            spwc_pkg::ST_FINISH: begin
                if (finish_go) begin
                    state_next = spwc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spwc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        issue     = 1'b0;
        finish_go = 1'b0;
        case (state_reg)
            spwc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            spwc_pkg::ST_RUN: begin
                issue = 1'b1;
            end
            spwc_pkg::ST_FINISH: begin
                finish_go = !m_tvalid_reg || m_tready;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign s_xfer = s_tvalid && s_tready;
    assign d2     = {1'b0, sq.dx2} + {1'b0, sq.dy2};

    always_comb begin
        joined       = (seen_reg >= spwc_pkg::WINDOW_FILL) && (best_reg < {1'b0, thr_sq_reg});
        nb_label     = win_label_reg[best_i_reg];
        fresh        = joined && (nb_label == '0);
        lab_cnt_next = lab_cnt_reg;
        if (fresh && lab_cnt_reg < spwc_pkg::LABEL_CAP) begin
            lab_cnt_next = lab_cnt_reg + 1'b1;
        end
        label = '0;
        back  = '0;
        if (joined) begin
            label = fresh ? lab_cnt_next : nb_label;
            back  = spwc_pkg::BACK_W'(best_i_reg) + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spwc_pkg::ST_IDLE;
            thr_reg      <= spwc_pkg::THR_RESET;
            seen_reg     <= '0;
            lab_cnt_reg  <= '0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                thr_reg <= cfg_wdata;
            end
            if (s_xfer) begin
                cnt_reg <= '0;
                if (s_tuser) begin
                    seen_reg    <= '0;
                    lab_cnt_reg <= '0;
                end
            end else if (issue) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (finish_go) begin
                lab_cnt_reg  <= lab_cnt_next;
                if (seen_reg < spwc_pkg::INDEX_MAX) begin
                    seen_reg <= seen_reg + 1'b1;
                end
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        thr_sq_reg <= spwc_pkg::SQ_W'(thr_reg) * spwc_pkg::SQ_W'(thr_reg);
        if (s_xfer) begin
            px_reg <= s_tdata[CW-1:0];
            py_reg <= s_tdata[2*CW-1:CW];
        end
        if (sq.vld && (sq.idx == '0 || d2 < best_reg)) begin
            best_reg   <= d2;
            best_i_reg <= sq.idx;
        end
        if (finish_go) begin
            win_x_reg[0]     <= px_reg;
            win_y_reg[0]     <= py_reg;
            win_label_reg[0] <= label;
            for (int j = 1; j < spwc_pkg::WINDOW; j++) begin
                win_x_reg[j] <= win_x_reg[j-1];
                win_y_reg[j] <= win_y_reg[j-1];
                if (fresh && best_i_reg == IW'(j - 1)) begin
                    win_label_reg[j] <= lab_cnt_next;
                end else begin
                    win_label_reg[j] <= win_label_reg[j-1];
                end
            end
            m_tdata_reg <= {1'b0, back, label, seen_reg};
            m_tuser_reg <= fresh;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
